// ----- sv/grhsv_pkg.sv -----
// Shared constants, types and register codes of the golden-ratio HSV colour unit.
package grhsv_pkg;

    localparam int ID_W       = 16;
    localparam int FRAC_W     = 16;
    localparam int HUE_SHIFT  = 32 - FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAC_W + 1;

    localparam logic [31:0] GOLDEN_Q32 = 32'h9E3779B9;

    localparam logic [FRAC_W:0] FX_ONE = {1'b1, {FRAC_W{1'b0}}};

    localparam logic [FRAC_W-1:0] RST_HUE =
        FRAC_W'(((64'd69 << FRAC_W) + 64'd50) / 64'd100);
    localparam logic [FRAC_W:0] RST_SATURATION =
        (FRAC_W + 1)'(((64'd85 << FRAC_W) + 64'd50) / 64'd100);
    localparam logic [FRAC_W:0] RST_BRIGHTNESS =
        (FRAC_W + 1)'(((64'd77 << FRAC_W) + 64'd50) / 64'd100);

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd2;

    localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
    localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

    typedef logic [FRAC_W-1:0] t_frac;
    typedef logic [FRAC_W:0]   t_unit;
    typedef logic [2:0]        t_sector;

    typedef struct packed {
        t_unit sat;
        t_unit val;
    } t_hsv_cfg;

endpackage

// ----- sv/grhsv_convert.sv -----
// HSV to RGB conversion pipeline: sector split, p, q and t terms and channel selection.
module grhsv_convert (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  grhsv_pkg::t_frac    i_hue,
    input  grhsv_pkg::t_hsv_cfg i_cfg,
    output logic                o_valid,
    output grhsv_pkg::t_unit    o_red,
    output grhsv_pkg::t_unit    o_green,
    output grhsv_pkg::t_unit    o_blue
);
    import grhsv_pkg::*;

    logic [FRAC_W+2:0]   w_h6;
    t_unit               w_one_minus_f;
    logic [2*FRAC_W:0]   w_fs;
    logic [2*FRAC_W:0]   w_nfs;
    logic [2*FRAC_W:0]   w_p_prod;
    logic [2*FRAC_W:0]   w_q_prod;
    logic [2*FRAC_W:0]   w_t_prod;

    logic                r2_valid;
    t_sector             r2_sector;
    t_frac               r2_frac;

    logic                r3_valid;
    t_sector             r3_sector;
    t_unit               r3_fs;
    t_unit               r3_nfs;

    logic                r4_valid;
    t_sector             r4_sector;
    t_unit               r4_p;
    t_unit               r4_q;
    t_unit               r4_t;

    logic                r5_valid;
    t_unit               r5_red;
    t_unit               r5_green;
    t_unit               r5_blue;
    t_unit               n_red;
    t_unit               n_green;
    t_unit               n_blue;

    assign w_h6 = (FRAC_W + 3)'(i_hue) * (FRAC_W + 3)'(3'd6);

    assign w_one_minus_f = FX_ONE - {1'b0, r2_frac};
    assign w_fs  = (2 * FRAC_W + 1)'(r2_frac) * (2 * FRAC_W + 1)'(i_cfg.sat);
    assign w_nfs = (2 * FRAC_W + 1)'(w_one_minus_f) * (2 * FRAC_W + 1)'(i_cfg.sat);

    assign w_p_prod = (2 * FRAC_W + 1)'(i_cfg.val) * (2 * FRAC_W + 1)'(FX_ONE - i_cfg.sat);
    assign w_q_prod = (2 * FRAC_W + 1)'(i_cfg.val) * (2 * FRAC_W + 1)'(FX_ONE - r3_fs);
    assign w_t_prod = (2 * FRAC_W + 1)'(i_cfg.val) * (2 * FRAC_W + 1)'(FX_ONE - r3_nfs);

    always_comb begin
        case (r4_sector)
            SEC_RED_YELLOW: begin
                n_red = i_cfg.val; n_green = r4_t;      n_blue = r4_p;
            end
            SEC_YELLOW_GREEN: begin
                n_red = r4_q;      n_green = i_cfg.val; n_blue = r4_p;
            end
            SEC_GREEN_CYAN: begin
                n_red = r4_p;      n_green = i_cfg.val; n_blue = r4_t;
            end
            SEC_CYAN_BLUE: begin
                n_red = r4_p;      n_green = r4_q;      n_blue = i_cfg.val;
            end
            SEC_BLUE_MAGENTA: begin
                n_red = r4_t;      n_green = r4_p;      n_blue = i_cfg.val;
            end
            SEC_MAGENTA_RED: begin
                n_red = i_cfg.val; n_green = r4_p;      n_blue = r4_q;
            end
            default: begin
                n_red = i_cfg.val; n_green = r4_p;      n_blue = r4_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r2_valid <= i_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sector <= w_h6[FRAC_W+2:FRAC_W];
        r2_frac   <= w_h6[FRAC_W-1:0];

        r3_sector <= r2_sector;
        r3_fs     <= w_fs[2*FRAC_W:FRAC_W];
        r3_nfs    <= w_nfs[2*FRAC_W:FRAC_W];

        r4_sector <= r3_sector;
        r4_p      <= w_p_prod[2*FRAC_W:FRAC_W];
        r4_q      <= w_q_prod[2*FRAC_W:FRAC_W];
        r4_t      <= w_t_prod[2*FRAC_W:FRAC_W];

        r5_red    <= n_red;
        r5_green  <= n_green;
        r5_blue   <= n_blue;
    end

    assign o_valid = r5_valid;
    assign o_red   = r5_red;
    assign o_green = r5_green;
    assign o_blue  = r5_blue;

endmodule

// ----- sv/golden_ratio_hsv_color_unit.sv -----
// Top level of the golden-ratio colour unit: configuration registers, hue stage and converter.
//
// A beat enters on the command channel: color_id is taken at a rising edge where start is
// high and busy is low. Busy is high only while reset is held, so one beat can be issued in
// every cycle. Each beat produces one colour on o_red, o_green and o_blue, shown for exactly
// one cycle with o_valid high; the receiver cannot stall, so results simply leave in order.
// Throughput is one beat per cycle, since each of the five register stages (hue multiply,
// sector split, fraction products, channel products, selection) takes a new beat in every
// cycle, and an accepted beat moves through them in that order to the outputs.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data: index zero is the
// initial hue, one the saturation and two the brightness; other indices are ignored. Writes
// are meant for idle periods only, once the result of the last beat has left.
// Saturation and brightness above one are clamped to one.
// Reset is synchronous and active low: it restores the default hue, saturation and
// brightness and drops every beat in flight.
module golden_ratio_hsv_color_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [grhsv_pkg::ID_W-1:0]          i_color_id,
    input  logic                                i_cfg_we,
    input  logic [grhsv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [grhsv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_valid,
    output grhsv_pkg::t_unit                    o_red,
    output grhsv_pkg::t_unit                    o_green,
    output grhsv_pkg::t_unit                    o_blue
);
    import grhsv_pkg::*;

    t_frac              r_initial_hue;
    t_unit              r_saturation;
    t_unit              r_brightness;
    t_frac              n_initial_hue;
    t_unit              n_saturation;
    t_unit              n_brightness;

    t_hsv_cfg           r_cfg;
    t_hsv_cfg           n_cfg;

    logic               w_accept;
    logic [ID_W+31:0]   w_prod;
    logic [31:0]        w_acc;

    logic               r1_valid;
    t_frac              r1_hue;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_comb begin
        n_initial_hue = r_initial_hue;
        n_saturation  = r_saturation;
        n_brightness  = r_brightness;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INITIAL_HUE: n_initial_hue = i_cfg_data[FRAC_W-1:0];
                CFG_SATURATION:  n_saturation  = i_cfg_data;
                CFG_BRIGHTNESS:  n_brightness  = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_cfg.sat = (r_saturation > FX_ONE) ? FX_ONE : r_saturation;
        n_cfg.val = (r_brightness > FX_ONE) ? FX_ONE : r_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_hue <= RST_HUE;
            r_saturation  <= RST_SATURATION;
            r_brightness  <= RST_BRIGHTNESS;
            r_cfg.sat     <= RST_SATURATION;
            r_cfg.val     <= RST_BRIGHTNESS;
        end else begin
            r_initial_hue <= n_initial_hue;
            r_saturation  <= n_saturation;
            r_brightness  <= n_brightness;
            r_cfg         <= n_cfg;
        end
    end

    assign w_prod = (ID_W + 32)'(i_color_id) * (ID_W + 32)'(GOLDEN_Q32);
    assign w_acc  = w_prod[31:0] + {r_initial_hue, {HUE_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_hue <= w_acc[31:HUE_SHIFT];
    end

    grhsv_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .i_hue   (r1_hue),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

// ----- sv/grhsv_checker.sv -----
// Port-level checks of the golden-ratio colour unit and the bind that attaches them.
module grhsv_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input grhsv_pkg::t_unit o_red,
    input grhsv_pkg::t_unit o_green,
    input grhsv_pkg::t_unit o_blue
);
    import grhsv_pkg::*;

    // Every accepted beat produces a result strobe on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted beat did not produce a result after five cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result strobe without a matching accepted beat");

    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= FX_ONE && o_green <= FX_ONE && o_blue <= FX_ONE))
        else $error("colour component above one");

endmodule

bind golden_ratio_hsv_color_unit grhsv_checker u_grhsv_checker (.*);

// ----- tb/golden_ratio_hsv_color_unit_tb.sv -----
// Self-checking testbench of the golden-ratio HSV colour unit: a directed table, then random phases.
`timescale 1ns / 1ps

module golden_ratio_hsv_color_unit_tb;
    import grhsv_pkg::*;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RANDOM_BEATS = 850;
    localparam logic [31:0] GOLDEN_STEP  = 32'h9E3779B9;
    localparam logic [33:0] UNIT         = 34'd65536;
    localparam t_frac       HUE_AT_RESET = 16'd45220;
    localparam t_unit       SAT_AT_RESET = 17'd55706;
    localparam t_unit       VAL_AT_RESET = 17'd50463;
    localparam t_unit       ONE_U        = 17'd65536;
    localparam t_unit       MAX_U        = 17'h1FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_unit red;
        t_unit green;
        t_unit blue;
    } t_rgb;

    typedef struct packed {
        t_frac           hue;
        t_unit           sat;
        t_unit           val;
        logic [ID_W-1:0] id;
        logic            known;
        t_rgb            rgb;
    } t_row;

    localparam t_rgb NO_RGB = '0;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [ID_W-1:0]       i_color_id;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    t_unit                 o_red;
    t_unit                 o_green;
    t_unit                 o_blue;

    t_frac hue_reg;
    t_unit sat_reg;
    t_unit val_reg;
    t_rgb  colour_q [$];
    logic  beat_known;
    t_rgb  beat_rgb;
    int    err_count;
    int    beats_in;
    int    colours_checked;
    int    settings_used;

    t_row directed [18] = '{
        '{HUE_AT_RESET, SAT_AT_RESET, VAL_AT_RESET, 16'h0000, 1'b0, NO_RGB},
        '{HUE_AT_RESET, SAT_AT_RESET, VAL_AT_RESET, 16'hFFFF, 1'b0, NO_RGB},
        '{HUE_AT_RESET, SAT_AT_RESET, VAL_AT_RESET, 16'h0001, 1'b0, NO_RGB},
        '{16'h0000, 17'd0, ONE_U, 16'h0000, 1'b1, '{ONE_U, ONE_U, ONE_U}},
        '{16'h0000, 17'd0, 17'd0, 16'hFFFF, 1'b1, '{17'd0, 17'd0, 17'd0}},
        '{16'h0000, ONE_U, ONE_U, 16'h0000, 1'b1, '{ONE_U, 17'd0, 17'd0}},
        '{16'h0000, MAX_U, MAX_U, 16'h0000, 1'b1, '{ONE_U, 17'd0, 17'd0}},
        '{16'h8000, ONE_U, ONE_U, 16'h0000, 1'b1, '{17'd0, ONE_U, ONE_U}},
        '{16'hFFFF, ONE_U, ONE_U, 16'h0000, 1'b1, '{ONE_U, 17'd0, 17'd6}},
        '{16'h3000, 17'd40000, 17'd60000, 16'h0000, 1'b0, NO_RGB},
        '{16'h6000, 17'd40000, 17'd60000, 16'h0000, 1'b0, NO_RGB},
        '{16'hB000, 17'd40000, 17'd60000, 16'h0000, 1'b0, NO_RGB},
        '{16'hE000, 17'd40000, 17'd60000, 16'h0000, 1'b0, NO_RGB},
        '{16'h0000, 17'd40000, 17'd60000, 16'h5555, 1'b0, NO_RGB},
        '{16'h0000, 17'd40000, 17'd60000, 16'hAAAA, 1'b0, NO_RGB},
        '{16'h3000, 17'd30000, 17'd100000, 16'h1234, 1'b0, NO_RGB},
        '{16'hFFFF, 17'd65537, 17'd65537, 16'hFF00, 1'b0, NO_RGB},
        '{16'h0000, 17'd70000, ONE_U, 16'h00FF, 1'b0, NO_RGB}
    };

    golden_ratio_hsv_color_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_color_id (i_color_id),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_rgb golden_colour(input logic [ID_W-1:0] id);
        logic [31:0]  acc;
        t_frac        h;
        logic [18:0]  h6;
        t_sector      sector;
        logic [33:0]  f;
        logic [33:0]  s;
        logic [33:0]  v;
        t_unit        vv;
        t_unit        pv;
        t_unit        qv;
        t_unit        tv;
        t_rgb         c;
        acc    = (32'(hue_reg) << HUE_SHIFT) + 32'(id) * GOLDEN_STEP;
        h      = acc[31:HUE_SHIFT];
        h6     = 19'(h) * 19'd6;
        sector = h6[18:FRAC_W];
        f      = 34'(h6[FRAC_W-1:0]);
        s      = (sat_reg > ONE_U) ? UNIT : 34'(sat_reg);
        v      = (val_reg > ONE_U) ? UNIT : 34'(val_reg);
        vv     = t_unit'(v);
        pv     = t_unit'((v * (UNIT - s)) >> FRAC_W);
        qv     = t_unit'((v * (UNIT - ((f * s) >> FRAC_W))) >> FRAC_W);
        tv     = t_unit'((v * (UNIT - (((UNIT - f) * s) >> FRAC_W))) >> FRAC_W);
        case (sector)
            SEC_RED_YELLOW:   c = '{red: vv, green: tv, blue: pv};
            SEC_YELLOW_GREEN: c = '{red: qv, green: vv, blue: pv};
            SEC_GREEN_CYAN:   c = '{red: pv, green: vv, blue: tv};
            SEC_CYAN_BLUE:    c = '{red: pv, green: qv, blue: vv};
            SEC_BLUE_MAGENTA: c = '{red: tv, green: pv, blue: vv};
            default:          c = '{red: vv, green: pv, blue: qv};
        endcase
        return c;
    endfunction

    function automatic t_unit pick_unit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_U;
            2:       return MAX_U;
            3:       return t_unit'($urandom_range(65537, 131071));
            default: return t_unit'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return ID_W'($urandom);
        endcase
    endfunction

    function automatic int gap_len(input bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    task automatic send(input logic [ID_W-1:0] id, input logic known, input t_rgb rgb);
        @(negedge i_clk);
        start      <= 1'b1;
        i_color_id <= id;
        beat_known = known;
        beat_rgb   = rgb;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_color_id <= ID_W'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (colour_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_unit data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_INITIAL_HUE: hue_reg = data[FRAC_W-1:0];
            CFG_SATURATION:  sat_reg = data;
            CFG_BRIGHTNESS:  val_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(input t_frac hue, input t_unit sat, input t_unit val);
        settle();
        write_reg(CFG_INITIAL_HUE, {1'($urandom), hue});
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_BRIGHTNESS, val);
        write_reg(CFG_UNUSED, t_unit'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Results are checked before the beat taken at the same edge is queued.
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (colour_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("%0t: unexpected colour r=%0d g=%0d b=%0d",
                                 $realtime, o_red, o_green, o_blue);
                    end
                end else begin
                    want = colour_q.pop_front();
                    colours_checked++;
                    if (want.red !== o_red || want.green !== o_green || want.blue !== o_blue) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%0t: colour mismatch, expected r=%0d g=%0d b=%0d,",
                                     $realtime, want.red, want.green, want.blue,
                                     " got r=%0d g=%0d b=%0d",
                                     o_red, o_green, o_blue);
                        end
                    end
                end
            end
            if (start && !busy) begin
                colour_q.push_back(beat_known ? beat_rgb : golden_colour(i_color_id));
                beats_in++;
            end
        end
    end

    initial begin
        t_row row;
        int   n_rand;
        int   burst;
        bit   steady;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_color_id      = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        beat_known      = 1'b0;
        beat_rgb        = '0;
        hue_reg         = HUE_AT_RESET;
        sat_reg         = SAT_AT_RESET;
        val_reg         = VAL_AT_RESET;
        err_count       = 0;
        beats_in        = 0;
        colours_checked = 0;
        settings_used   = 1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            row = directed[k];
            if ({row.hue, row.sat, row.val} != {hue_reg, sat_reg, val_reg}) begin
                configure(row.hue, row.sat, row.val);
            end
            send(row.id, row.known, row.rgb);
            pause(gap_len(1'b0));
        end

        n_rand = 0;
        while (n_rand < RANDOM_BEATS) begin
            configure(t_frac'($urandom), pick_unit(), pick_unit());
            burst  = $urandom_range(30, 120);
            if (burst > RANDOM_BEATS - n_rand) begin
                burst = RANDOM_BEATS - n_rand;
            end
            steady = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                send(pick_id(), 1'b0, NO_RGB);
                pause(gap_len(steady));
                n_rand++;
            end
        end

        settle();
        $display("Run covered %0d colour requests under %0d register settings.",
                 beats_in, settings_used);
        $display("%0d colours compared, %0d mismatches.", colours_checked, err_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
